// ===== rtl/ps2hl_pkg.sv =====
package ps2hl_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // request codes
    localparam logic [1:0] REQ_EDGE  = 2'd0;
    localparam logic [1:0] REQ_QUEUE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_START  = 3'd1;
    localparam logic [2:0] ERR_STOP   = 3'd2;
    localparam logic [2:0] ERR_PARITY = 3'd3;
    localparam logic [2:0] ERR_ACK    = 3'd4;

    // frame bit positions
    localparam logic [3:0] POS_PARITY_TX = 4'd8;
    localparam logic [3:0] POS_PARITY    = 4'd9;
    localparam logic [3:0] POS_RELEASE   = 4'd9;
    localparam logic [3:0] POS_STOP      = 4'd10;
    localparam logic [3:0] POS_ACK       = 4'd10;
    localparam logic [3:0] POS_DONE      = 4'd11;

    typedef struct packed {
        logic [1:0] req_type;
        logic       data_bit;
        logic [7:0] send_byte;
    } in_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_byte;
        logic [2:0] error_code;
        logic       data_drive_enable;
        logic       data_drive_value;
        logic       start_request;
        logic       send_pending;
        logic       transmitting;
    } out_t;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + QPTR_W'(1);
        return r;
    endfunction

endpackage

// ===== rtl/ps2hl_core.sv =====
module ps2hl_core
    import ps2hl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  in_t  item,
    output out_t result
);

    logic [3:0]        bit_pos_reg, bit_pos_next;
    logic [7:0]        shift_reg, shift_next;
    logic              odd_reg, odd_next;
    logic              resync_reg, resync_next;
    logic              sending_reg, sending_next;
    logic              de_reg, de_next;
    logic              dl_reg, dl_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [7:0]        queue_mem [QUEUE_DEPTH];
    logic [7:0]        head_reg;

    logic       rx_valid;
    logic [7:0] rx_val;
    logic [2:0] err;
    logic       start;
    logic       tx_b;

    always_comb
    begin
        bit_pos_next = bit_pos_reg;
        shift_next   = shift_reg;
        odd_next     = odd_reg;
        resync_next  = resync_reg;
        sending_next = sending_reg;
        de_next      = de_reg;
        dl_next      = dl_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        rx_valid     = 1'b0;
        rx_val       = 8'd0;
        err          = ERR_NONE;
        start        = 1'b0;
        tx_b         = 1'b0;

        if (fire)
        begin
            unique case (item.req_type)
                REQ_EDGE:
                begin
                    if (sending_reg)
                    begin
                        if (bit_pos_next <= POS_PARITY_TX)
                        begin
                            if (bit_pos_next == POS_PARITY_TX)
                                tx_b = ~odd_next;
                            else
                            begin
                                tx_b     = shift_next[bit_pos_next[2:0]];
                                odd_next = odd_next ^ tx_b;
                            end
                            de_next      = 1'b1;
                            dl_next      = tx_b;
                            bit_pos_next = bit_pos_next + 4'd1;
                        end
                        else if (bit_pos_next == POS_RELEASE)
                        begin
                            de_next      = 1'b0;
                            dl_next      = 1'b0;
                            bit_pos_next = bit_pos_next + 4'd1;
                        end
                        else if (bit_pos_next == POS_ACK)
                        begin
                            if (item.data_bit)
                                err = ERR_ACK;
                            shift_next   = 8'd0;
                            bit_pos_next = 4'd0;
                            odd_next     = 1'b0;
                            sending_next = 1'b0;
                            de_next      = 1'b0;
                            dl_next      = 1'b0;
                        end
                        else
                            bit_pos_next = bit_pos_next + 4'd1;
                    end
                    else
                    begin
                        // a low bit while resyncing restarts the frame
                        if (resync_next && !item.data_bit)
                        begin
                            shift_next   = 8'd0;
                            bit_pos_next = 4'd0;
                            odd_next     = 1'b0;
                            resync_next  = 1'b0;
                        end
                        if (bit_pos_next == 4'd0 && item.data_bit)
                        begin
                            err         = ERR_START;
                            resync_next = 1'b1;
                        end
                        else if (bit_pos_next == POS_STOP && !item.data_bit)
                        begin
                            err         = ERR_STOP;
                            resync_next = 1'b1;
                        end
                        else if (bit_pos_next == POS_PARITY && item.data_bit == odd_next)
                        begin
                            err         = ERR_PARITY;
                            resync_next = 1'b1;
                        end
                        else
                        begin
                            if (bit_pos_next >= 4'd1 && bit_pos_next <= 4'd8 && item.data_bit)
                            begin
                                shift_next[3'(bit_pos_next - 4'd1)] = 1'b1;
                                odd_next = ~odd_next;
                            end
                            bit_pos_next = bit_pos_next + 4'd1;
                            if (bit_pos_next >= POS_DONE)
                            begin
                                rx_valid     = 1'b1;
                                rx_val       = shift_next;
                                shift_next   = 8'd0;
                                bit_pos_next = 4'd0;
                                odd_next     = 1'b0;
                            end
                        end
                    end
                end
                REQ_QUEUE:
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                REQ_TICK:
                begin
                    if (!sending_reg && wr_ptr_reg != rd_ptr_reg)
                    begin
                        shift_next   = head_reg;
                        rd_ptr_next  = ptr_inc(rd_ptr_reg);
                        bit_pos_next = 4'd0;
                        odd_next     = 1'b0;
                        sending_next = 1'b1;
                        de_next      = 1'b1;
                        dl_next      = 1'b0;
                        start        = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        result.byte_valid        = rx_valid;
        result.rx_byte           = rx_val;
        result.error_code        = err;
        result.data_drive_enable = de_next;
        result.data_drive_value  = de_next & dl_next;
        result.start_request     = start;
        result.send_pending      = (wr_ptr_next != rd_ptr_next);
        result.transmitting      = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg <= 4'd0;
            shift_reg   <= 8'd0;
            odd_reg     <= 1'b0;
            resync_reg  <= 1'b0;
            sending_reg <= 1'b0;
            de_reg      <= 1'b0;
            dl_reg      <= 1'b0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
        end
        else
        begin
            bit_pos_reg <= bit_pos_next;
            shift_reg   <= shift_next;
            odd_reg     <= odd_next;
            resync_reg  <= resync_next;
            sending_reg <= sending_next;
            de_reg      <= de_next;
            dl_reg      <= dl_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
        end
    end

    // head_reg always holds the entry at the read pointer; a write to that
    // slot in the same cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (fire && item.req_type == REQ_QUEUE)
            queue_mem[wr_ptr_reg] <= item.send_byte;
        if (fire && item.req_type == REQ_QUEUE && wr_ptr_reg == rd_ptr_next)
            head_reg <= item.send_byte;
        else
            head_reg <= queue_mem[rd_ptr_next];
    end

endmodule

// ===== rtl/ps2_host_link_unit.sv =====
// Every accepted input beat yields exactly one result beat, registered into the output buffer.
// Throughput: one input beat per cycle while the output buffer is not full.
// A two-entry output buffer lets one more input beat in while a result waits.
// Reset (rst_n, async, active low) clears frame state, queue pointers and the buffer;
// send queue contents are not cleared and are only read after being written.
module ps2_host_link_unit
    import ps2hl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic       fire;
    logic       pop;
    out_t       result;
    out_t       buf0_reg, buf0_next;
    out_t       buf1_reg, buf1_next;
    logic [1:0] cnt_reg, cnt_next;

    assign in_ready  = (cnt_reg != 2'd2);
    assign fire      = in_valid & in_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid & out_ready;
    assign out_data  = buf0_reg;

    ps2hl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_data),
        .result (result)
    );

    always_comb
    begin
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        cnt_next  = cnt_reg;
        unique case ({fire, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    buf0_next = result;
                else
                    buf1_next = result;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                buf0_next = buf1_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                // pop and push together: input is closed when two are held,
                // so only one can be held here
                if (cnt_reg == 2'd1)
                    buf0_next = result;
                else
                begin
                    buf0_next = buf1_reg;
                    buf1_next = result;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

endmodule

// ===== rtl/ps2hl_checker.sv =====
module ps2hl_checker
    import ps2hl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // an accepted input always leaves a result offered next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

    // a started send drives the start bit low and is transmitting
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.start_request |->
            out_data.transmitting && out_data.data_drive_enable &&
            !out_data.data_drive_value)
        else $error("start beat without drive of start bit");

    // a received byte never coincides with an error or an active send
    a_rx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_valid |->
            out_data.error_code == ERR_NONE && !out_data.transmitting)
        else $error("received byte with error or during send");

    // drive only while a frame is being sent
    a_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.data_drive_enable |-> out_data.transmitting)
        else $error("data driven outside a send");

endmodule

bind ps2_host_link_unit ps2hl_checker u_ps2hl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
